// ===== src/lodd_pkg.sv =====
// Package for the lock-order deadlock detector.
// Holds sizes, status codes and the result word type; no dependencies.
package lodd_pkg;

    localparam int NUM_LOCKS   = 16;
    localparam int STACK_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int LOCK_W      = 4;
    localparam int CNT_W       = 5;
    localparam int ORD_W       = 5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_WRONG    = 3'd2;
    localparam logic [2:0] ST_DEADLOCK = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;
    localparam logic [2:0] ST_HALTED   = 3'd5;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic [2:0]        status;
        logic [LOCK_W-1:0] edge_from;
        logic [LOCK_W-1:0] edge_to;
        logic              last;
    } result_t;

endpackage

// ===== src/lodd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lodd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/lodd_core.sv =====
// Sequencer: held stack, order matrix in RAM, depth-first cycle search.
// Depends on lodd_pkg and lodd_ram.
module lodd_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [lodd_pkg::LOCK_W-1:0]   in_lock,
    output logic                          res_valid,
    input  logic                          res_ready,
    output lodd_pkg::result_t             res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TOP   = 4'd1;
    localparam logic [3:0] S_ROW   = 4'd2;
    localparam logic [3:0] S_CLR   = 4'd3;
    localparam logic [3:0] S_ROOT  = 4'd4;
    localparam logic [3:0] S_HEAD  = 4'd5;
    localparam logic [3:0] S_HROW  = 4'd6;
    localparam logic [3:0] S_SCAN  = 4'd7;
    localparam logic [3:0] S_REP   = 4'd8;
    localparam logic [3:0] S_CHAIN = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_PUSH  = 4'd11;
    localparam logic [3:0] S_INIT  = 4'd12;

    localparam int LW = lodd_pkg::LOCK_W;
    localparam int CW = lodd_pkg::CNT_W;
    localparam int NL = lodd_pkg::NUM_LOCKS;

    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic          halted_reg, halted_next;
    logic          op_reg;
    logic [LW-1:0] id_reg, top_reg;
    lodd_pkg::result_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;
    logic [LW-1:0] clr_reg, clr_next;

    logic [NL-1:0] visited_reg, visited_next;
    logic [NL-1:0] done_reg, done_next;
    logic [lodd_pkg::ORD_W-1:0] ord_reg [NL];
    logic [LW-1:0] from_reg [NL];
    logic [LW-1:0] nb_reg [NL];
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] root_reg;
    logic [LW-1:0] h_reg, now_reg, there_reg;
    logic [CW-1:0] nres_reg;
    logic [CW-1:0] jscan;
    logic          jfound;

    // matrix RAM
    logic          m_we;
    logic [LW-1:0] m_waddr, m_raddr;
    logic [NL-1:0] m_wdata, m_rdata;
    // held stack RAM
    logic          h_we;
    logic [LW-1:0] h_waddr, h_raddr, h_rdata;
    // search stack RAM
    logic          s_we;
    logic [LW-1:0] s_waddr, s_raddr, s_rdata;
    logic [LW-1:0] s_wdata;

    lodd_ram #(.WIDTH(NL), .DEPTH(NL)) u_matrix (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata));
    lodd_ram #(.WIDTH(LW), .DEPTH(lodd_pkg::STACK_DEPTH)) u_held (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(id_reg),
        .raddr(h_raddr), .rdata(h_rdata));
    lodd_ram #(.WIDTH(LW), .DEPTH(NL)) u_sstack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // next set neighbor at or above nb_reg[h] in the fetched row
    always_comb
    begin
        jfound = 1'b0;
        jscan  = CW'(NL);
        for (int k = NL - 1; k >= 0; k--)
        begin
            if (m_rdata[k] && (CW'(k) >= {1'b0, nb_reg[h_reg]}))
            begin
                jfound = 1'b1;
                jscan  = CW'(k);
            end
        end
    end

    logic nb_wrapped_reg [NL];

    always_comb
    begin
        state_next      = state_reg;
        held_count_next = held_count_reg;
        halted_next     = halted_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        clr_next        = clr_reg;
        sp_next         = sp_reg;
        visited_next    = visited_reg;
        done_next       = done_reg;
        m_we = 1'b0; m_waddr = top_reg; m_wdata = m_rdata | (NL'(1) << id_reg);
        m_raddr = top_reg;
        h_we = 1'b0; h_waddr = held_count_reg[LW-1:0];
        h_raddr = LW'(held_count_reg - CW'(1));
        s_we = 1'b0; s_waddr = '0; s_wdata = '0;
        s_raddr = LW'(sp_reg - CW'(1));
        if (out_valid_reg && res_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_INIT:
            begin
                m_we = 1'b1; m_waddr = clr_reg; m_wdata = '0;
                clr_next = clr_reg + LW'(1);
                if (clr_reg == LW'(NL - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_TOP;
                end
            end
            S_TOP:
            begin
                // held stack top read is in flight
                state_next = S_ROW;
            end
            S_ROW:
            begin
                out_next = '{status: lodd_pkg::ST_OK, edge_from: '0, edge_to: '0,
                             last: 1'b1};
                m_raddr = h_rdata;
                state_next = S_OUT;
                if (halted_reg)
                begin
                    out_next.status = lodd_pkg::ST_HALTED;
                end
                else if (op_reg == lodd_pkg::OP_ACQUIRE)
                begin
                    if (held_count_reg >= CW'(lodd_pkg::STACK_DEPTH))
                    begin
                        out_next.status = lodd_pkg::ST_OVERFLOW;
                    end
                    else if (held_count_reg != '0 && h_rdata != id_reg)
                    begin
                        state_next = S_CLR;
                    end
                    else
                    begin
                        state_next = S_PUSH;
                    end
                end
                else
                begin
                    if (held_count_reg == '0)
                    begin
                        out_next.status = lodd_pkg::ST_EMPTY;
                    end
                    else if (h_rdata != id_reg)
                    begin
                        out_next.status = lodd_pkg::ST_WRONG;
                    end
                    else
                    begin
                        held_count_next = held_count_reg - CW'(1);
                    end
                end
            end
            S_CLR:
            begin
                // row of top is valid now
                if (m_rdata[id_reg])
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    m_we = 1'b1;
                    visited_next = '0;
                    done_next = '0;
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_reg >= CW'(NL))
                begin
                    state_next = S_PUSH;
                end
                else if (visited_reg[root_reg[LW-1:0]])
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    visited_next[root_reg[LW-1:0]] = 1'b1;
                    s_we = 1'b1; s_waddr = '0; s_wdata = root_reg[LW-1:0];
                    sp_next = CW'(1);
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                if (sp_reg == '0)
                begin
                    state_next = S_ROOT;
                end
                else
                begin
                    state_next = S_HROW;
                end
            end
            S_HROW:
            begin
                m_raddr = s_rdata;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (!jfound || nb_wrapped_reg[h_reg])
                begin
                    done_next[h_reg] = 1'b1;
                    sp_next = sp_reg - CW'(1);
                    state_next = S_HEAD;
                end
                else if (!visited_reg[jscan[LW-1:0]])
                begin
                    visited_next[jscan[LW-1:0]] = 1'b1;
                    if (sp_reg < CW'(NL))
                    begin
                        s_we = 1'b1; s_waddr = sp_reg[LW-1:0];
                        s_wdata = jscan[LW-1:0];
                        sp_next = sp_reg + CW'(1);
                    end
                    state_next = S_HEAD;
                end
                else if (ord_reg[h_reg] < ord_reg[jscan[LW-1:0]] ||
                         done_reg[jscan[LW-1:0]])
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    out_next = '{status: lodd_pkg::ST_DEADLOCK, edge_from: h_reg,
                                 edge_to: jscan[LW-1:0], last: 1'b0};
                    out_valid_next = 1'b1;
                    halted_next = 1'b1;
                    state_next = S_REP;
                end
            end
            S_REP:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    out_next = '{status: lodd_pkg::ST_DEADLOCK,
                                 edge_from: from_reg[now_reg], edge_to: now_reg,
                                 last: (from_reg[now_reg] == there_reg) ||
                                       (nres_reg >= CW'(lodd_pkg::MAX_RESULTS - 1))};
                    out_valid_next = 1'b1;
                    state_next = out_next.last ? S_IDLE : S_REP;
                end
            end
            S_PUSH:
            begin
                h_we = 1'b1;
                held_count_next = held_count_reg + CW'(1);
                out_next = '{status: lodd_pkg::ST_OK, edge_from: '0, edge_to: '0,
                             last: 1'b1};
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            held_count_reg <= '0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            sp_reg         <= '0;
            visited_reg    <= '0;
            done_reg       <= '0;
            clr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            halted_reg     <= halted_next;
            out_valid_reg  <= out_valid_next;
            sp_reg         <= sp_next;
            visited_reg    <= visited_next;
            done_reg       <= done_next;
            clr_reg        <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (state_reg == S_IDLE && in_valid && in_ready)
        begin
            op_reg <= in_op;
            id_reg <= in_lock;
        end
        if (state_reg == S_ROW)
        begin
            top_reg <= h_rdata;
        end
        if (state_reg == S_CLR)
        begin
            root_reg  <= '0;
            count_reg <= '0;
            for (int k = 0; k < NL; k++)
            begin
                nb_reg[k]         <= '0;
                nb_wrapped_reg[k] <= 1'b0;
                from_reg[k]       <= '0;
            end
        end
        if (state_reg == S_ROOT)
        begin
            if (root_reg < CW'(NL) && !visited_reg[root_reg[LW-1:0]])
            begin
                ord_reg[root_reg[LW-1:0]] <= count_reg;
                count_reg <= count_reg + CW'(1);
            end
            root_reg <= root_reg + CW'(1);
        end
        if (state_reg == S_HROW)
        begin
            h_reg <= s_rdata;
        end
        if (state_reg == S_SCAN && jfound && !nb_wrapped_reg[h_reg])
        begin
            nb_reg[h_reg] <= jscan[LW-1:0] + LW'(1);
            if (jscan == CW'(NL - 1))
            begin
                nb_wrapped_reg[h_reg] <= 1'b1;
            end
            if (!visited_reg[jscan[LW-1:0]])
            begin
                from_reg[jscan[LW-1:0]] <= h_reg;
                ord_reg[jscan[LW-1:0]]  <= count_reg;
                count_reg <= count_reg + CW'(1);
            end
            now_reg   <= h_reg;
            there_reg <= jscan[LW-1:0];
            nres_reg  <= CW'(1);
        end
        if (state_reg == S_REP && (!out_valid_reg || res_ready))
        begin
            now_reg  <= from_reg[now_reg];
            nres_reg <= nres_reg + CW'(1);
        end
    end

endmodule

// ===== src/lock_order_deadlock_detector.sv =====
// Top level of the lock-order deadlock detector.
// Stream ports around lodd_core; depends on lodd_pkg and lodd_core.
//
// s_axis carries one request word: op (acquire or release) and lock number.
// m_axis returns result words: status, the edge of a reported cycle and
// tlast on the final word caused by that request.
// A release, an overflow or a halted request gives its word via S_OUT;
// a push passes S_PUSH first; an acquire along a known edge, S_CLR and S_PUSH.
// The next request is taken the cycle after the result word is taken.
// An acquire that adds a new order edge runs a depth-first search over the
// matrix RAM: one neighbor step (S_HEAD, S_HROW, S_SCAN) per set bit and
// per finished lock, plus root steps in S_ROOT for each lock and in S_HEAD for each new root.
// A found cycle streams one word per cycle while the receiver is ready,
// closing edge first, then the parent chain; the block then halts and
// answers every request with the halted status.
// Reset clears the held count, the halted flag and control state, then an
// S_INIT pass zeroes the order matrix RAM row by row while s_axis_tready stays low.
// When the receiver stalls, the result word holds and no request is taken.
module lock_order_deadlock_detector (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [0] op, [4:1] lock_id
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [2:0] status, [6:3] edge_from, [10:7] edge_to
    output logic       m_axis_tlast
);

    lodd_pkg::result_t res;

    lodd_core u_core (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[0]), .in_lock(s_axis_tdata[4:1]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res));

    assign m_axis_tdata = {5'b0, res.edge_to, res.edge_from, res.status};
    assign m_axis_tlast = res.last;

endmodule

// ===== test/tb.sv =====
// Testbench for lock_order_deadlock_detector: drives acquire/release words, predicts
// status and cycle-edge results in a scoreboard class and checks every result word.
// Depends on lodd_pkg and the detector RTL.
`timescale 1ns / 1ps

module tb;

    class lock_scoreboard;
        bit [15:0]   order_rows [16];
        bit [3:0]    held [16];
        int          held_cnt;
        bit          stopped;
        lodd_pkg::result_t pending [$];

        function new();
            foreach (order_rows[i]) order_rows[i] = '0;
            held_cnt = 0;
            stopped  = 0;
        endfunction

        function int find_cycle(bit [15:0] rows [16], output lodd_pkg::result_t found [$]);
            int vord [16];
            bit vis [16];
            bit dn [16];
            int par [16];
            int stk [16];
            int nxt [16];
            int cnt, sp, h, j, now, steps;
            found = {};
            cnt = 0;
            for (int i = 0; i < 16; i++)
            begin
                vord[i] = 0; vis[i] = 0; dn[i] = 0; par[i] = 0; nxt[i] = 0; stk[i] = 0;
            end
            for (int root = 0; root < 16; root++)
            begin
                if (vis[root])
                    continue;
                vis[root]  = 1;
                vord[root] = cnt++;
                sp = 0;
                stk[sp++] = root;
                while (sp > 0)
                begin
                    h = stk[sp-1];
                    j = nxt[h];
                    while (j < 16 && !rows[h][j])
                        j++;
                    if (j >= 16)
                    begin
                        dn[h] = 1;
                        sp--;
                        continue;
                    end
                    nxt[h] = j + 1;
                    if (!vis[j])
                    begin
                        par[j]  = h;
                        vis[j]  = 1;
                        vord[j] = cnt++;
                        if (sp < 16)
                            stk[sp++] = j;
                        continue;
                    end
                    if (vord[h] < vord[j])
                        continue;
                    if (!dn[j])
                    begin
                        found.push_back('{lodd_pkg::ST_DEADLOCK, h[3:0], j[3:0], 1'b0});
                        now = h;
                        for (steps = 0;
                             steps < 16 && found.size() < lodd_pkg::MAX_RESULTS; steps++)
                        begin
                            found.push_back('{lodd_pkg::ST_DEADLOCK, par[now][3:0],
                                              now[3:0], 1'b0});
                            now = par[now];
                            if (now == j)
                                break;
                        end
                        found[found.size()-1].last = 1'b1;
                        return found.size();
                    end
                end
            end
            return 0;
        endfunction

        function bit would_deadlock(bit op, bit [3:0] id);
            bit [15:0] trial [16];
            lodd_pkg::result_t dummy [$];
            bit [3:0]  top;
            if (stopped || op == lodd_pkg::OP_RELEASE ||
                held_cnt >= lodd_pkg::STACK_DEPTH || held_cnt == 0)
                return 0;
            top = held[held_cnt-1];
            if (top == id || order_rows[top][id])
                return 0;
            trial = order_rows;
            trial[top][id] = 1'b1;
            return find_cycle(trial, dummy) > 0;
        endfunction

        function void note(bit op, bit [3:0] id);
            lodd_pkg::result_t found [$];
            bit [3:0] top;
            logic [2:0] st;
            st = lodd_pkg::ST_OK;
            if (stopped)
                st = lodd_pkg::ST_HALTED;
            else if (op == lodd_pkg::OP_ACQUIRE)
            begin
                if (held_cnt >= lodd_pkg::STACK_DEPTH)
                    st = lodd_pkg::ST_OVERFLOW;
                else
                begin
                    if (held_cnt > 0)
                    begin
                        top = held[held_cnt-1];
                        if (top != id && !order_rows[top][id])
                        begin
                            order_rows[top][id] = 1'b1;
                            if (find_cycle(order_rows, found) > 0)
                            begin
                                stopped = 1;
                                foreach (found[i]) pending.push_back(found[i]);
                                return;
                            end
                        end
                    end
                    held[held_cnt++] = id;
                end
            end
            else
            begin
                if (held_cnt == 0)
                    st = lodd_pkg::ST_EMPTY;
                else if (held[held_cnt-1] != id)
                    st = lodd_pkg::ST_WRONG;
                else
                    held_cnt--;
            end
            pending.push_back('{st, 4'd0, 4'd0, 1'b1});
        endfunction

        function string check(logic [2:0] st, logic [3:0] ef, logic [3:0] et, logic lst);
            lodd_pkg::result_t e;
            if (pending.size() == 0)
                return $sformatf("unexpected word st=%0d %0d->%0d last=%0b", st, ef, et, lst);
            e = pending.pop_front();
            if (st !== e.status || ef !== e.edge_from || et !== e.edge_to || lst !== e.last)
                return $sformatf("got st=%0d %0d->%0d last=%0b, want st=%0d %0d->%0d last=%0b",
                                 st, ef, et, lst, e.status, e.edge_from, e.edge_to, e.last);
            return "";
        endfunction
    endclass

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    lock_scoreboard sb;
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;
    string msg;

    lock_order_deadlock_detector dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    task report(input string text);
        $display("tb: mismatch: %s", text);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles  <= 0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                msg = sb.check(m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[10:7],
                               m_axis_tlast);
                if (msg != "")
                    report(msg);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    task send_word(input bit op, input bit [3:0] id);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, id, op};
        do @(posedge clk); while (!s_axis_tready);
        sb.note(op, id);
    endtask

    // skip any request that would close a deadlock loop before the final phase
    task send_safe(input bit op, input bit [3:0] id);
        if (!sb.would_deadlock(op, id))
            send_word(op, id);
    endtask

    task run_sequence();
        bit [3:0] locks [$];
        bit [3:0] cur;
        int k;
        k = $urandom_range(1, 4);
        cur = 4'($urandom_range(0, 12));
        for (int i = 0; i < k; i++)
        begin
            locks.push_back(cur);
            if (cur < 15 && $urandom_range(3) != 0)
                cur = 4'($urandom_range(cur + 1, 15));
        end
        foreach (locks[i]) send_safe(lodd_pkg::OP_ACQUIRE, locks[i]);
        if ($urandom_range(9) == 0)
            send_safe(lodd_pkg::OP_RELEASE, 4'($urandom_range(15)));
        for (int i = locks.size() - 1; i >= 0; i--)
            send_safe(lodd_pkg::OP_RELEASE, locks[i]);
    endtask

    task drain_stack();
        while (sb.held_cnt > 0)
            send_word(lodd_pkg::OP_RELEASE, sb.held[sb.held_cnt-1]);
    endtask

    initial
    begin
        bit [3:0] a, b;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_word(lodd_pkg::OP_RELEASE, 4'd0);
        send_word(lodd_pkg::OP_ACQUIRE, 4'd0);
        send_word(lodd_pkg::OP_ACQUIRE, 4'd15);
        send_word(lodd_pkg::OP_RELEASE, 4'd0);
        send_word(lodd_pkg::OP_RELEASE, 4'd15);
        send_word(lodd_pkg::OP_ACQUIRE, 4'd15);
        repeat (16) send_word(lodd_pkg::OP_ACQUIRE, 4'd15);
        drain_stack();
        send_word(lodd_pkg::OP_RELEASE, 4'd15);

        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int i = 0; i < 21; i++)
            begin
                if ($urandom_range(4) == 0)
                    send_safe(1'($urandom_range(1)), 4'($urandom_range(15)));
                else
                    run_sequence();
            end
        end

        drain_stack();
        a = 4'($urandom_range(0, 15));
        b = 4'($urandom_range(0, 15));
        if (b == a)
            b = a + 4'd1;
        send_word(lodd_pkg::OP_ACQUIRE, a);
        send_word(lodd_pkg::OP_ACQUIRE, b);
        send_word(lodd_pkg::OP_RELEASE, b);
        send_word(lodd_pkg::OP_RELEASE, a);
        send_word(lodd_pkg::OP_ACQUIRE, b);
        send_word(lodd_pkg::OP_ACQUIRE, a);
        repeat (8) send_word(1'($urandom_range(1)), 4'($urandom_range(15)));
        s_axis_tvalid <= 1'b0;

        while (sb.pending.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
src/lodd_pkg.sv
src/lodd_ram.sv
src/lodd_core.sv
src/lock_order_deadlock_detector.sv
test/tb.sv
